FILE: rtl/stx_length_packet_deframer_core_assert.svh
// Assertion macros for the STX length-prefixed deframer checker.
// Depends on nothing; the including module supplies clock and reset.
`ifndef STX_LENGTH_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define STX_LENGTH_PACKET_DEFRAMER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STXD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define STXD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

FILE: rtl/stxd_pkg.sv
// Shared types and constants for the STX length-prefixed deframer.
// Used by the parser, the top level and the checker; depends on nothing.
`default_nettype none

package stxd_pkg;

   localparam int unsigned LEN_W   = 14;
   localparam int unsigned HC_W    = 3;
   localparam int unsigned PHASE_W = 3;

   localparam logic [7:0] STX_BYTE   = 8'h02;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_TAG     = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DELIM   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   typedef struct packed {
      logic       hit;
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       first_byte;
   } stxd_result_type;

endpackage

`default_nettype wire

FILE: rtl/stxd_parser.sv
// Frame parser state machine: hunt, tag, length, delimiter and payload phases.
// Depends on stxd_pkg; the result it offers is combinational from the current byte.
`default_nettype none

module stxd_parser #(
   parameter int unsigned LEN_DIGITS = 4,
   parameter int unsigned TAG_BYTES  = 3
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               rx_byte,
   input  wire logic                     clear,
   output      stxd_pkg::stxd_result_type result
);
   import stxd_pkg::*;

   localparam logic [HC_W-1:0] TAG_END = HC_W'(TAG_BYTES + 1);
   localparam logic [HC_W-1:0] LEN_END = HC_W'(LEN_DIGITS);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [HC_W-1:0]    header_count_ff, header_count_in;
   logic [LEN_W-1:0]   length_accum_ff, length_accum_in;
   logic [LEN_W-1:0]   payload_left_ff, payload_left_in;
   logic               at_first_ff, at_first_in;

   logic [HC_W-1:0]  hc_inc;
   logic             is_digit;
   logic [3:0]       digit;
   logic [LEN_W-1:0] accum_x10;

   assign hc_inc    = header_count_ff + HC_W'(1);
   assign is_digit  = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
   assign digit     = rx_byte[3:0];
   assign accum_x10 = {length_accum_ff[LEN_W-4:0], 3'b000}
                    + {length_accum_ff[LEN_W-2:0], 1'b0};

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      length_accum_in = length_accum_ff;
      payload_left_in = payload_left_ff;
      at_first_in     = at_first_ff;
      result          = '0;
      if (clear) begin
         phase_in        = PH_HUNT;
         header_count_in = '0;
         length_accum_in = '0;
         payload_left_in = '0;
         at_first_in     = 1'b1;
      end else if ((phase_ff != PH_HUNT) && (rx_byte == STX_BYTE)) begin
         phase_in        = PH_TAG;
         header_count_in = '0;
         length_accum_in = '0;
         payload_left_in = '0;
         at_first_in     = 1'b1;
         result.hit      = 1'b1;
         result.kind     = KIND_ABORT;
      end else begin
         case (phase_ff)
            PH_TAG: begin
               header_count_in = hc_inc;
               if (hc_inc >= TAG_END) begin
                  phase_in        = PH_LEN;
                  header_count_in = '0;
                  length_accum_in = '0;
               end
            end
            PH_LEN: begin
               if (!is_digit) begin
                  phase_in        = PH_HUNT;
                  header_count_in = '0;
                  length_accum_in = '0;
                  payload_left_in = '0;
                  at_first_in     = 1'b1;
                  result.hit      = 1'b1;
                  result.kind     = KIND_ABORT;
               end else begin
                  length_accum_in = accum_x10 + LEN_W'(digit);
                  header_count_in = hc_inc;
                  if (hc_inc >= LEN_END) begin
                     phase_in        = PH_DELIM;
                     header_count_in = '0;
                  end
               end
            end
            PH_DELIM: begin
               if (length_accum_ff == '0) begin
                  phase_in        = PH_HUNT;
                  header_count_in = '0;
                  length_accum_in = '0;
                  payload_left_in = '0;
                  at_first_in     = 1'b1;
                  result.hit      = 1'b1;
                  result.kind     = KIND_EMPTY;
               end else begin
                  payload_left_in = length_accum_ff;
                  at_first_in     = 1'b1;
                  phase_in        = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               result.hit        = 1'b1;
               result.kind       = KIND_DATA;
               result.data_byte  = rx_byte;
               result.last_byte  = (payload_left_ff <= LEN_W'(1));
               result.first_byte = at_first_ff;
               payload_left_in   = payload_left_ff - LEN_W'(1);
               at_first_in       = 1'b0;
               if (payload_left_ff <= LEN_W'(1)) begin
                  phase_in        = PH_HUNT;
                  header_count_in = '0;
                  length_accum_in = '0;
                  payload_left_in = '0;
                  at_first_in     = 1'b1;
               end
            end
            default: begin
               phase_in        = (rx_byte == STX_BYTE) ? PH_TAG : PH_HUNT;
               header_count_in = '0;
               length_accum_in = '0;
               payload_left_in = '0;
               at_first_in     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         header_count_ff <= '0;
         length_accum_ff <= '0;
         payload_left_ff <= '0;
         at_first_ff     <= 1'b1;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         length_accum_ff <= length_accum_in;
         payload_left_ff <= payload_left_in;
         at_first_ff     <= at_first_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/stx_length_packet_deframer_core.sv
// Channel  Ports                                             Direction
// req      req_valid req_stall req_rx_byte req_clear         in (stall out)
// rsp      rsp_valid rsp_stall rsp_kind rsp_data_byte        out (stall in)
//          rsp_last_byte rsp_first_byte
// A byte is taken every cycle unless req_stall is high; any result it gives is registered.
// The rate is set by the single parser step between the input and result registers.
// Reset is synchronous and returns the parser to the STX hunt with no beat pending.
// req_stall rises only while a result waits in a stalled result register and the
// pending byte would give another result.
// Top level of the STX length-prefixed deframer; depends on stxd_pkg and stxd_parser.
`default_nettype none

module stx_length_packet_deframer_core #(
   parameter int unsigned LEN_DIGITS = 4,
   parameter int unsigned TAG_BYTES  = 3
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_clear,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [1:0] rsp_kind,
   output      logic [7:0] rsp_data_byte,
   output      logic       rsp_last_byte,
   output      logic       rsp_first_byte
);
   import stxd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_clear_ff;

   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff;
   logic [7:0] out_data_ff;
   logic       out_last_ff;
   logic       out_first_ff;

   stxd_result_type result;
   logic            advance;
   logic            req_take;

   stxd_parser #(
      .LEN_DIGITS (LEN_DIGITS),
      .TAG_BYTES  (TAG_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .clear   (in_clear_ff),
      .result  (result)
   );

   assign advance   = in_valid_ff && (!result.hit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && result.hit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_rx_byte;
         in_clear_ff <= req_clear;
      end
      if (advance && result.hit) begin
         out_kind_ff  <= result.kind;
         out_data_ff  <= result.data_byte;
         out_last_ff  <= result.last_byte;
         out_first_ff <= result.first_byte;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_data_byte  = out_data_ff;
   assign rsp_last_byte  = out_last_ff;
   assign rsp_first_byte = out_first_ff;

endmodule

`default_nettype wire

FILE: rtl/stxd_checker.sv
// Port-level checks for the STX length-prefixed deframer, bound to the top level.
// Depends on stxd_pkg and the assertion macro header.
`default_nettype none

`include "stx_length_packet_deframer_core_assert.svh"

module stxd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_data_byte,
   input wire logic       rsp_last_byte,
   input wire logic       rsp_first_byte
);
   import stxd_pkg::*;

   `STXD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) &&
      $stable(rsp_last_byte) && $stable(rsp_first_byte))
   `STXD_ASSERT_SAME(a_kind_known, rsp_valid,
      rsp_kind == KIND_DATA || rsp_kind == KIND_EMPTY || rsp_kind == KIND_ABORT)
   `STXD_ASSERT_SAME(a_ctrl_clean, rsp_valid && rsp_kind != KIND_DATA,
      rsp_data_byte == 8'd0 && !rsp_last_byte && !rsp_first_byte)
   `STXD_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   `STXD_ASSERT_SAME(a_quiet_after_reset, $fell(reset), !rsp_valid && !req_stall)

endmodule

bind stx_length_packet_deframer_core stxd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_last_byte  (rsp_last_byte),
   .rsp_first_byte (rsp_first_byte)
);

`default_nettype wire
